>>> rtl/vfts_pkg.sv
// ----------------------------------------------------------------------------
// vfts_pkg
// Shared types and constants for the voxel field trilinear sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vfts_pkg;

    localparam int VOLUME_WORDS_DEF = 262144;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int STEP_SHIFT_DEF   = 10;

    localparam int DATA_W    = 32;
    localparam int VADDR_W   = 18;
    localparam int CELL_W    = 7;
    localparam int CIDX_W    = 22;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_DIST  = 2'd1;
    localparam logic [1:0] MODE_GRAD  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z  = 3'd6;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_DIST  = 2'd1,
        OP_GRAD  = 2'd2
    } t_op;

    typedef struct packed {
        t_op                       op;
        logic [VADDR_W-1:0]        addr;
        logic signed [DATA_W-1:0]  value;
        logic signed [DATA_W-1:0]  px;
        logic signed [DATA_W-1:0]  py;
        logic signed [DATA_W-1:0]  pz;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] org_x;
        logic signed [DATA_W-1:0] org_y;
        logic signed [DATA_W-1:0] org_z;
        logic [DATA_W-1:0]        inv;
        logic [CELL_W-1:0]        cx;
        logic [CELL_W-1:0]        cy;
        logic [CELL_W-1:0]        cz;
    } t_cfg;

    typedef struct packed {
        logic                     in_grid;
        logic signed [DATA_W-1:0] dist_val;
        logic signed [DATA_W-1:0] gx;
        logic signed [DATA_W-1:0] gy;
        logic signed [DATA_W-1:0] gz;
    } t_res;

endpackage

`default_nettype wire

>>> rtl/vfts_front.sv
// ----------------------------------------------------------------------------
// vfts_front
// Request intake: accepts requests, drops unused modes, queues the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vfts_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [1:0]                         i_mode,
    input  wire logic [vfts_pkg::VADDR_W-1:0]       i_voxel_address,
    input  wire logic signed [vfts_pkg::DATA_W-1:0] i_voxel_value,
    input  wire logic signed [vfts_pkg::DATA_W-1:0] i_point_x,
    input  wire logic signed [vfts_pkg::DATA_W-1:0] i_point_y,
    input  wire logic signed [vfts_pkg::DATA_W-1:0] i_point_z,
    output logic                                    o_q_valid,
    input  wire logic                               i_q_ready,
    output vfts_pkg::t_req                          o_q
);
    import vfts_pkg::*;

    t_req       r_q [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push, w_pop;
    t_req       w_req;
    logic       w_keep;

    always_comb begin
        w_req.addr  = i_voxel_address;
        w_req.value = i_voxel_value;
        w_req.px    = i_point_x;
        w_req.py    = i_point_y;
        w_req.pz    = i_point_z;
        w_keep      = 1'b1;
        case (i_mode)
            MODE_WRITE: w_req.op = OP_WRITE;
            MODE_DIST:  w_req.op = OP_DIST;
            MODE_GRAD:  w_req.op = OP_GRAD;
            default: begin
                w_req.op = OP_WRITE;
                w_keep   = 1'b0;
            end
        endcase
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready && w_keep;
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_pop     = o_q_valid && i_q_ready;
    assign o_q       = r_q[r_rptr];

    always_comb begin
        n_wptr = w_push ? ~r_wptr : r_wptr;
        n_rptr = w_pop ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_req;
        end
    end

endmodule

`default_nettype wire

>>> rtl/vfts_engine.sv
// ----------------------------------------------------------------------------
// vfts_engine
// Back end: volume memory, cell lookup, corner fetch, interpolation, gradient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vfts_engine #(
    parameter int VOLUME_WORDS = vfts_pkg::VOLUME_WORDS_DEF,
    parameter int FRAC_BITS    = vfts_pkg::FRAC_BITS_DEF,
    parameter int STEP_SHIFT   = vfts_pkg::STEP_SHIFT_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire vfts_pkg::t_cfg i_cfg,
    input  wire logic           i_q_valid,
    output logic                o_q_ready,
    input  wire vfts_pkg::t_req i_q,
    output logic                o_valid,
    input  wire logic           i_ready,
    output vfts_pkg::t_res      o_res
);
    import vfts_pkg::*;

    localparam int AW     = $clog2(VOLUME_WORDS);
    localparam int K      = (STEP_SHIFT < FRAC_BITS) ? STEP_SHIFT : FRAC_BITS;
    localparam int STEP_I = 1 << (FRAC_BITS - K);
    localparam int GSH    = K - 1;
    localparam int PROD_W = 58;
    localparam int HI_W   = 50;
    localparam int LP_W   = DATA_W + 2 + FRAC_BITS;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_AXP  = 11'b000_0000_0010,
        ST_AXM  = 11'b000_0000_0100,
        ST_AXL  = 11'b000_0000_1000,
        ST_ADR1 = 11'b000_0001_0000,
        ST_ADR2 = 11'b000_0010_0000,
        ST_RD   = 11'b000_0100_0000,
        ST_LM   = 11'b000_1000_0000,
        ST_LA   = 11'b001_0000_0000,
        ST_SMP  = 11'b010_0000_0000,
        ST_FIN  = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [DATA_W-1:0] mem [VOLUME_WORDS];
    logic [DATA_W-1:0] r_mem_q;
    logic              r_rd_vld;
    logic              r_rd_oob;

    t_req                     r_req;
    logic [2:0]               r_samp;
    logic [1:0]               r_axis;
    logic [33:0]              r_m;
    logic                     r_neg;
    logic [HI_W-1:0]          r_hi;
    logic [CELL_W-1:0]        r_ix, r_iy, r_iz;
    logic [FRAC_BITS-1:0]     r_hx, r_hy, r_hz;
    logic [2*CELL_W-1:0]      r_cxy;
    logic [3*CELL_W-1:0]      r_zpart;
    logic [2*CELL_W-1:0]      r_ypart;
    logic [CIDX_W-1:0]        r_base;
    logic [3:0]               r_cnt;
    logic signed [DATA_W-1:0] r_v [8];
    logic [2:0]               r_lop;
    logic signed [LP_W-1:0]   r_lprod;
    logic signed [DATA_W-1:0] r_m0;
    logic signed [DATA_W-1:0] r_gx, r_gy, r_gz;
    logic                     r_fail;
    logic                     r_ovld;
    t_res                     r_ores;

    // point and cell lookup
    logic signed [DATA_W-1:0] w_pt, w_org;
    logic [CELL_W-1:0]        w_cells;
    logic signed [33:0]       w_off, w_p34;
    logic signed [34:0]       w_d35;
    logic [HI_W-1:0]          w_lo;
    logic [PROD_W-1:0]        w_prod, w_ci;
    logic                     w_afail;

    always_comb begin
        case (r_axis)
            2'd0: begin
                w_pt = r_req.px; w_org = i_cfg.org_x; w_cells = i_cfg.cx;
            end
            2'd1: begin
                w_pt = r_req.py; w_org = i_cfg.org_y; w_cells = i_cfg.cy;
            end
            default: begin
                w_pt = r_req.pz; w_org = i_cfg.org_z; w_cells = i_cfg.cz;
            end
        endcase
        if (r_req.op == OP_GRAD && r_samp[2:1] == r_axis) begin
            w_off = r_samp[0] ? 34'(STEP_I) : -34'(STEP_I);
        end else begin
            w_off = 34'sd0;
        end
        w_p34   = 34'(w_pt) + w_off;
        w_d35   = 35'(w_p34) - 35'(w_org);
        w_lo    = r_m * i_cfg.inv[15:0];
        w_prod  = {r_hi[PROD_W-17:0], 16'd0} + PROD_W'(w_lo);
        w_ci    = w_prod >> (2 * FRAC_BITS);
        w_afail = (|r_hi[HI_W-1:40]) || (r_neg && (w_prod != '0))
                  || ((w_ci + PROD_W'(1)) >= PROD_W'(w_cells));
    end

    // corner fetch
    logic [CIDX_W-1:0] w_caddr;
    logic [31:0]       w_caddr32, w_waddr32;
    logic              w_rd_en, w_wr_en, w_coob;

    always_comb begin
        w_caddr = r_base + CIDX_W'(r_cnt[0])
                  + (r_cnt[1] ? CIDX_W'(i_cfg.cx) : '0)
                  + (r_cnt[2] ? CIDX_W'(r_cxy) : '0);
        w_caddr32 = 32'(w_caddr);
        w_coob    = (w_caddr32 >= 32'(VOLUME_WORDS));
        w_rd_en   = (r_state == ST_RD) && (r_cnt != 4'd8);
        w_waddr32 = 32'(i_q.addr);
        w_wr_en   = (r_state == ST_IDLE) && i_q_valid && (i_q.op == OP_WRITE)
                    && (w_waddr32 < 32'(VOLUME_WORDS));
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_waddr32[AW-1:0]] <= i_q.value;
        end
        if (w_rd_en) begin
            r_mem_q  <= mem[w_caddr32[AW-1:0]];
            r_rd_oob <= w_coob;
        end
    end

    // interpolation
    logic [FRAC_BITS-1:0]     w_h;
    logic signed [32:0]       w_diff;
    logic signed [DATA_W-1:0] w_lres;
    logic [2:0]               w_pos;
    logic signed [32:0]       w_gd;
    logic signed [47:0]       w_gs;
    logic signed [DATA_W-1:0] w_gsat;

    always_comb begin
        if (r_lop < 3'd4) begin
            w_h = r_hx;
        end else if (r_lop < 3'd6) begin
            w_h = r_hy;
        end else begin
            w_h = r_hz;
        end
        w_diff = 33'(r_v[1]) - 33'(r_v[0]);
        w_lres = r_v[0] + DATA_W'(r_lprod >>> FRAC_BITS);
        w_pos  = 3'd6 - r_lop;
        w_gd   = 33'(r_v[0]) - 33'(r_m0);
        w_gs   = 48'(w_gd) <<< GSH;
        if ((&w_gs[47:31]) || !(|w_gs[47:31])) begin
            w_gsat = w_gs[31:0];
        end else begin
            w_gsat = w_gs[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    assign o_q_ready = (r_state == ST_IDLE);

    logic w_load;
    assign w_load = (r_state == ST_FIN) && (!r_ovld || i_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && i_q.op != OP_WRITE) begin
                    n_state = ST_AXP;
                end
            end
            ST_AXP:  n_state = ST_AXM;
            ST_AXM:  n_state = ST_AXL;
            ST_AXL: begin
                if (w_afail) begin
                    n_state = ST_FIN;
                end else if (r_axis == 2'd2) begin
                    n_state = ST_ADR1;
                end else begin
                    n_state = ST_AXP;
                end
            end
            ST_ADR1: n_state = ST_ADR2;
            ST_ADR2: n_state = ST_RD;
            ST_RD: begin
                if (r_cnt == 4'd8) begin
                    n_state = ST_LM;
                end
            end
            ST_LM:   n_state = ST_LA;
            ST_LA:   n_state = (r_lop == 3'd6) ? ST_SMP : ST_LM;
            ST_SMP: begin
                if (r_req.op == OP_GRAD && r_samp != 3'd5) begin
                    n_state = ST_AXP;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_rd_en;
            if (w_load) begin
                r_ovld <= 1'b1;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_req  <= i_q;
                r_samp <= 3'd0;
                r_axis <= 2'd0;
                r_fail <= 1'b0;
                r_cxy  <= i_cfg.cx * i_cfg.cy;
            end
            ST_AXP: begin
                r_neg <= w_d35[34];
                r_m   <= w_d35[34] ? 34'(-w_d35) : 34'(w_d35);
            end
            ST_AXM: begin
                r_hi <= r_m * i_cfg.inv[31:16];
            end
            ST_AXL: begin
                r_fail <= w_afail;
                r_axis <= r_axis + 2'd1;
                case (r_axis)
                    2'd0: begin
                        r_ix <= w_ci[CELL_W-1:0];
                        r_hx <= w_prod[2*FRAC_BITS-1:FRAC_BITS];
                    end
                    2'd1: begin
                        r_iy <= w_ci[CELL_W-1:0];
                        r_hy <= w_prod[2*FRAC_BITS-1:FRAC_BITS];
                    end
                    default: begin
                        r_iz <= w_ci[CELL_W-1:0];
                        r_hz <= w_prod[2*FRAC_BITS-1:FRAC_BITS];
                    end
                endcase
            end
            ST_ADR1: begin
                r_zpart <= r_iz * r_cxy;
                r_ypart <= r_iy * i_cfg.cx;
            end
            ST_ADR2: begin
                r_base <= CIDX_W'(r_zpart) + CIDX_W'(r_ypart) + CIDX_W'(r_ix);
                r_cnt  <= 4'd0;
            end
            ST_RD: begin
                if (r_cnt != 4'd8) begin
                    r_cnt <= r_cnt + 4'd1;
                end
                r_lop <= 3'd0;
            end
            ST_LM: begin
                r_lprod <= LP_W'(w_diff) * LP_W'($signed({1'b0, w_h}));
            end
            ST_LA: begin
                r_lop <= r_lop + 3'd1;
            end
            ST_SMP: begin
                r_axis <= 2'd0;
                r_samp <= r_samp + 3'd1;
                if (!r_samp[0]) begin
                    r_m0 <= r_v[0];
                end else begin
                    case (r_samp[2:1])
                        2'd0:    r_gx <= w_gsat;
                        2'd1:    r_gy <= w_gsat;
                        default: r_gz <= w_gsat;
                    endcase
                end
            end
            ST_FIN: begin
                if (w_load) begin
                    r_ores.in_grid  <= !r_fail;
                    r_ores.dist_val <= (!r_fail && r_req.op == OP_DIST) ? r_v[0] : '0;
                    r_ores.gx       <= (!r_fail && r_req.op == OP_GRAD) ? r_gx : '0;
                    r_ores.gy       <= (!r_fail && r_req.op == OP_GRAD) ? r_gy : '0;
                    r_ores.gz       <= (!r_fail && r_req.op == OP_GRAD) ? r_gz : '0;
                end
            end
            default: begin
            end
        endcase
    end

    // corner queue: filled from memory, then consumed two at a time by the lerps
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            for (int i = 0; i < 7; i++) begin
                r_v[i] <= r_v[i+1];
            end
            r_v[7] <= r_rd_oob ? '0 : $signed(r_mem_q);
        end else if (r_state == ST_LA) begin
            for (int i = 0; i < 6; i++) begin
                if (3'(i) != w_pos) begin
                    r_v[i] <= r_v[i+2];
                end
            end
            r_v[w_pos] <= w_lres;
        end
    end

    assign o_valid = r_ovld;
    assign o_res   = r_ores;

    a_rd_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> (r_cnt <= 4'd8))
        else $error("corner counter overran");

    a_lerp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LM || r_state == ST_LA) |-> (r_lop <= 3'd6))
        else $error("lerp step counter overran");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !r_ores.in_grid) |-> (r_ores.dist_val == '0 && r_ores.gx == '0
                                         && r_ores.gy == '0 && r_ores.gz == '0))
        else $error("outside result carries nonzero fields");

    a_write_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_q_valid && i_q.op == OP_WRITE) |=> (r_state == ST_IDLE))
        else $error("voxel write left idle");

endmodule

`default_nettype wire

>>> rtl/voxel_field_trilinear_sampler.sv
// ----------------------------------------------------------------------------
// voxel_field_trilinear_sampler
// Fixed-point distance volume with trilinear distance and gradient sampling.
// ----------------------------------------------------------------------------
// Requests enter on i_valid/o_ready; mode 0 writes one voxel, mode 1 samples
// the distance at a point, mode 2 forms a central-difference gradient from six
// samples. Mode 3 is taken and dropped. Results leave on o_valid/i_ready, one
// per sample request, none for writes.
// Registers are written through i_cfg_valid/o_cfg_ready (always ready); the
// user must write them only while the block is idle; the block does not enforce it.
// A two-entry request queue sits in front of the sequencer, and the result is
// held in an output register, so requests keep flowing while a result waits.
// Sequencing: a write is done in the sequencer's idle state; a distance sample
// runs an axis lookup per axis, 8 single-port memory reads and 7 lerps in turn;
// a gradient runs six samples. The sequencer takes a new request only when idle.
// The single memory port and the shared lerp multiplier set the pace.
// Reset clears control and restores register defaults; volume contents are
// undefined until written. A stalled receiver holds the result and, once the
// queue fills, backpressures o_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module voxel_field_trilinear_sampler #(
    parameter int VOLUME_WORDS = vfts_pkg::VOLUME_WORDS_DEF,
    parameter int FRAC_BITS    = vfts_pkg::FRAC_BITS_DEF,
    parameter int STEP_SHIFT   = vfts_pkg::STEP_SHIFT_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [1:0]                           i_mode,
    input  wire logic [vfts_pkg::VADDR_W-1:0]         i_voxel_address,
    input  wire logic signed [vfts_pkg::DATA_W-1:0]   i_voxel_value,
    input  wire logic signed [vfts_pkg::DATA_W-1:0]   i_point_x,
    input  wire logic signed [vfts_pkg::DATA_W-1:0]   i_point_y,
    input  wire logic signed [vfts_pkg::DATA_W-1:0]   i_point_z,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic                                      o_inside_res,
    output logic signed [vfts_pkg::DATA_W-1:0]        o_distance_value,
    output logic signed [vfts_pkg::DATA_W-1:0]        o_grad_x,
    output logic signed [vfts_pkg::DATA_W-1:0]        o_grad_y,
    output logic signed [vfts_pkg::DATA_W-1:0]        o_grad_z,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [vfts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [vfts_pkg::DATA_W-1:0]          i_cfg_data
);
    import vfts_pkg::*;

    t_cfg r_cfg;
    logic w_q_valid, w_q_ready;
    t_req w_q;
    t_res w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.org_x <= '0;
            r_cfg.org_y <= '0;
            r_cfg.org_z <= '0;
            r_cfg.inv   <= 32'd65536;
            r_cfg.cx    <= 7'd64;
            r_cfg.cy    <= 7'd64;
            r_cfg.cz    <= 7'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ORIGIN_X: r_cfg.org_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_cfg.org_y <= i_cfg_data;
                CFG_ORIGIN_Z: r_cfg.org_z <= i_cfg_data;
                CFG_INV_CELL: r_cfg.inv   <= i_cfg_data;
                CFG_CELLS_X:  r_cfg.cx    <= i_cfg_data[CELL_W-1:0];
                CFG_CELLS_Y:  r_cfg.cy    <= i_cfg_data[CELL_W-1:0];
                CFG_CELLS_Z:  r_cfg.cz    <= i_cfg_data[CELL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    vfts_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_voxel_address (i_voxel_address),
        .i_voxel_value   (i_voxel_value),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_point_z       (i_point_z),
        .o_q_valid       (w_q_valid),
        .i_q_ready       (w_q_ready),
        .o_q             (w_q)
    );

    vfts_engine #(
        .VOLUME_WORDS (VOLUME_WORDS),
        .FRAC_BITS    (FRAC_BITS),
        .STEP_SHIFT   (STEP_SHIFT)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .o_q_ready (w_q_ready),
        .i_q       (w_q),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_res     (w_res)
    );

    assign o_inside_res     = w_res.in_grid;
    assign o_distance_value = w_res.dist_val;
    assign o_grad_x         = w_res.gx;
    assign o_grad_y         = w_res.gy;
    assign o_grad_z         = w_res.gz;

endmodule

`default_nettype wire
